FILE: hdl/fhst_pkg.sv
// fhst_pkg: shared types and codes of the fermion hop sign tracker
// no dependencies; used by fhst_cell and fermion_hop_sign_tracker
`default_nettype none

package fhst_pkg;

    localparam int FIELD_W = 6;

    localparam logic [1:0] OP_PLACE = 2'd0;
    localparam logic [1:0] OP_HOP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic               fl;
        logic [FIELD_W-1:0] src;
        logic [FIELD_W-1:0] dst;
        logic [FIELD_W-1:0] lo;
        logic [FIELD_W-1:0] hi;
        logic [FIELD_W-1:0] part;
        logic               clr;
        logic               place;
        logic               hop;
    } t_cmd;

    // handed from one cell to the next every cycle
    typedef struct packed {
        logic               par;
        logic               src_occ;
        logic               dst_occ;
        logic [FIELD_W-1:0] pidx;
    } t_link;

endpackage

`default_nettype wire

FILE: hdl/fhst_cell.sv
// fhst_cell: one site of the chain, occupancy and particle index per flavour
// depends on fhst_pkg
`default_nettype none

module fhst_cell #(
    parameter int IDX      = 0,
    parameter int FLAVOURS = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire fhst_pkg::t_cmd  i_cmd,
    input  wire fhst_pkg::t_link i_link,
    output fhst_pkg::t_link    o_link
);
    import fhst_pkg::*;

    logic [FLAVOURS-1:0] r_occ;
    logic [FIELD_W-1:0]  r_pid [FLAVOURS];
    t_link               r_link;
    t_link               n_link;
    logic                w_occ;
    logic [FIELD_W-1:0]  w_pid;
    logic                w_at_src;
    logic                w_at_dst;
    logic                w_between;

    assign w_at_src  = (int'(i_cmd.src) == IDX);
    assign w_at_dst  = (int'(i_cmd.dst) == IDX);
    assign w_between = (int'(i_cmd.lo) < IDX) && (IDX < int'(i_cmd.hi));

    always_comb begin
        w_occ = 1'b0;
        w_pid = '0;
        for (int f = 0; f < FLAVOURS; f++) begin
            if (int'(i_cmd.fl) == f) begin
                w_occ = r_occ[f];
                w_pid = r_pid[f];
            end
        end
        n_link.par     = i_link.par ^ (w_occ & w_between);
        n_link.src_occ = i_link.src_occ | (w_occ & w_at_src);
        n_link.dst_occ = i_link.dst_occ | (w_occ & w_at_dst);
        n_link.pidx    = (w_at_src && w_occ) ? w_pid : i_link.pidx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.clr) begin
            r_occ <= '0;
        end else begin
            for (int f = 0; f < FLAVOURS; f++) begin
                if (int'(i_cmd.fl) == f) begin
                    if (i_cmd.hop && w_at_src) begin
                        r_occ[f] <= 1'b0;
                    end
                    if ((i_cmd.hop || i_cmd.place) && w_at_dst) begin
                        r_occ[f] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int f = 0; f < FLAVOURS; f++) begin
            if ((int'(i_cmd.fl) == f) && (i_cmd.hop || i_cmd.place) && w_at_dst) begin
                r_pid[f] <= i_cmd.part;
            end
        end
        r_link <= n_link;
    end

    assign o_link = r_link;

endmodule

`default_nettype wire

FILE: hdl/fermion_hop_sign_tracker.sv
// fermion_hop_sign_tracker: top level, controller and a row of SITES site cells
// flow: place and hop pass a sweep state while the link word runs through every site
// cell, then commit; others go straight to commit, as does a place or hop whose
// flavour, site or particle is out of range; throughput: one word at a time, the next
// word is taken only after the commit; a stalled result word holds the input off
// reset: synchronous active low, all sites empty and the sign +1
// depends on fhst_pkg and fhst_cell
`default_nettype none

module fermion_hop_sign_tracker #(
    parameter int FLAVOURS  = 2,
    parameter int SITES     = 64,
    parameter int PARTICLES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // op[1:0], flavour[2], from_site[8:3], to_site[14:9], particle[20:15]
    input  wire logic [23:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // sign_negative[0], hop_odd[1], moved_particle[7:2], bad_move[8]
    output logic [15:0]      m_axis_tdata
);
    import fhst_pkg::*;

    localparam int CNT_W = $clog2(SITES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_COMMIT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [1:0]         r_op;
    logic               r_fl;
    logic [FIELD_W-1:0] r_src;
    logic [FIELD_W-1:0] r_dst;
    logic [FIELD_W-1:0] r_lo;
    logic [FIELD_W-1:0] r_hi;
    logic [FIELD_W-1:0] r_part;
    logic               r_pre_bad;
    logic               r_sign;
    logic               r_ovalid;
    logic               r_o_sign;
    logic               r_o_odd;
    logic [FIELD_W-1:0] r_o_moved;
    logic               r_o_bad;

    logic [1:0]         w_op;
    logic               w_fl;
    logic [FIELD_W-1:0] w_src;
    logic [FIELD_W-1:0] w_dst;
    logic [FIELD_W-1:0] w_part;
    logic               w_pre_bad;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_fire;
    logic               n_sign;
    logic               n_odd;
    logic [FIELD_W-1:0] n_moved;
    logic               n_bad;
    t_cmd               w_cmd;
    t_link              w_link [SITES+1];

    assign w_op   = s_axis_tdata[1:0];
    assign w_fl   = s_axis_tdata[2];
    assign w_src  = s_axis_tdata[8:3];
    assign w_dst  = s_axis_tdata[14:9];
    assign w_part = s_axis_tdata[20:15];

    always_comb begin
        w_pre_bad = (int'(w_fl) >= FLAVOURS) || (int'(w_dst) >= SITES);
        if (w_op == OP_PLACE && int'(w_part) >= PARTICLES) begin
            w_pre_bad = 1'b1;
        end
        if (w_op == OP_HOP && int'(w_src) >= SITES) begin
            w_pre_bad = 1'b1;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign w_fire        = (r_state == ST_COMMIT) && w_out_free;

    always_comb begin
        n_sign      = r_sign;
        n_odd       = 1'b0;
        n_moved     = '0;
        n_bad       = 1'b0;
        w_cmd.fl    = r_fl;
        w_cmd.src   = r_src;
        w_cmd.dst   = r_dst;
        w_cmd.lo    = r_lo;
        w_cmd.hi    = r_hi;
        w_cmd.part  = r_part;
        w_cmd.clr   = 1'b0;
        w_cmd.place = 1'b0;
        w_cmd.hop   = 1'b0;
        case (r_op)
            OP_CLEAR: begin
                n_sign    = 1'b0;
                w_cmd.clr = w_fire;
            end
            OP_PLACE: begin
                if (r_pre_bad || w_link[SITES].dst_occ) begin
                    n_bad = 1'b1;
                end else begin
                    n_moved     = r_part;
                    w_cmd.place = w_fire;
                end
            end
            OP_HOP: begin
                if (r_pre_bad || !w_link[SITES].src_occ || w_link[SITES].dst_occ) begin
                    n_bad = 1'b1;
                end else begin
                    n_odd      = w_link[SITES].par;
                    n_sign     = r_sign ^ w_link[SITES].par;
                    n_moved    = w_link[SITES].pidx;
                    w_cmd.part = w_link[SITES].pidx;
                    w_cmd.hop  = w_fire;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_link[0] = '0;

    for (genvar g = 0; g < SITES; g++) begin : g_cell
        fhst_cell #(
            .IDX      (g),
            .FLAVOURS (FLAVOURS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_sign   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_cnt <= '0;
                        if ((w_op == OP_PLACE || w_op == OP_HOP) && !w_pre_bad) begin
                            r_state <= ST_SWEEP;
                        end else begin
                            r_state <= ST_COMMIT;
                        end
                    end
                end
                ST_SWEEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(SITES - 1)) begin
                        r_state <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    if (w_out_free) begin
                        r_sign   <= n_sign;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op      <= w_op;
            r_fl      <= w_fl;
            r_src     <= w_src;
            r_dst     <= w_dst;
            r_lo      <= (w_src < w_dst) ? w_src : w_dst;
            r_hi      <= (w_src < w_dst) ? w_dst : w_src;
            r_part    <= w_part;
            r_pre_bad <= w_pre_bad;
        end
        if (w_fire) begin
            r_o_sign  <= n_sign;
            r_o_odd   <= n_odd;
            r_o_moved <= n_moved;
            r_o_bad   <= n_bad;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_o_bad, r_o_moved, r_o_odd, r_o_sign};

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// testbench: self-checking bench for fermion_hop_sign_tracker, one word in and one word out
// tracks occupancy and particle indexes per flavour, and the one sign, to predict every result word
// depends on fhst_pkg and fermion_hop_sign_tracker

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fhst_pkg::*;

    localparam int N_FLAVOURS  = 2;
    localparam int N_SITES     = 64;
    localparam int N_PARTICLES = 64;
    localparam int STALL_LIMIT = 5000;

    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct packed {
        logic [5:0] particle;
        logic [5:0] to_site;
        logic [5:0] from_site;
        logic       flavour;
        logic [1:0] op;
    } op_word_t;

    typedef struct packed {
        logic       bad_move;
        logic [5:0] moved_particle;
        logic       hop_odd;
        logic       sign_negative;
    } hop_outcome_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // op[1:0], flavour[2], from_site[8:3], to_site[14:9], particle[20:15]
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // sign_negative[0], hop_odd[1], moved_particle[7:2], bad_move[8]
    logic [15:0] m_axis_tdata;

    bit           site_full [N_FLAVOURS][N_SITES];
    logic [5:0]   site_particle [N_FLAVOURS][N_SITES];
    bit           sign_neg;
    hop_outcome_t pending_outcomes[$];
    hop_outcome_t got_word;
    hop_outcome_t want_word;
    bit           no_idle = 1'b0;
    int unsigned  error_count = 0;
    int unsigned  result_count = 0;
    int unsigned  stall_cycles = 0;

    fermion_hop_sign_tracker #(
        .FLAVOURS (N_FLAVOURS),
        .SITES    (N_SITES),
        .PARTICLES(N_PARTICLES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic hop_outcome_t track_hop_sign(input op_word_t w);
        hop_outcome_t r;
        logic [5:0]   lo;
        logic [5:0]   hi;
        bit           odd;
        r = '0;
        odd = 1'b0;
        case (w.op)
            OP_CLEAR: begin
                site_full = '{default: 1'b0};
                sign_neg = 1'b0;
            end
            OP_PLACE: begin
                if (site_full[w.flavour][w.to_site]) begin
                    r.bad_move = 1'b1;
                end else begin
                    site_full[w.flavour][w.to_site] = 1'b1;
                    site_particle[w.flavour][w.to_site] = w.particle;
                    r.moved_particle = w.particle;
                end
            end
            OP_HOP: begin
                if (!site_full[w.flavour][w.from_site] || site_full[w.flavour][w.to_site]) begin
                    r.bad_move = 1'b1;
                end else begin
                    lo = (w.from_site < w.to_site) ? w.from_site : w.to_site;
                    hi = (w.from_site < w.to_site) ? w.to_site : w.from_site;
                    for (int s = int'(lo) + 1; s < int'(hi); s++)
                        odd ^= site_full[w.flavour][s];
                    site_full[w.flavour][w.from_site] = 1'b0;
                    site_full[w.flavour][w.to_site] = 1'b1;
                    site_particle[w.flavour][w.to_site] = site_particle[w.flavour][w.from_site];
                    sign_neg ^= odd;
                    r.hop_odd = odd;
                    r.moved_particle = site_particle[w.flavour][w.to_site];
                end
            end
            default: ;
        endcase
        r.sign_negative = sign_neg;
        return r;
    endfunction

    function automatic op_word_t make_word(input logic [1:0] op, input logic fl,
                                           input int src, input int dst, input int part);
        op_word_t w;
        w.op = op;
        w.flavour = fl;
        w.from_site = 6'(src);
        w.to_site = 6'(dst);
        w.particle = 6'(part);
        return w;
    endfunction

    // hops go from an occupied site to a free one, places land on free sites
    function automatic op_word_t pick_wellformed();
        op_word_t   w;
        logic [5:0] full_sites[$];
        logic [5:0] free_sites[$];
        int         roll;
        w = op_word_t'($urandom);
        roll = $urandom_range(99);
        for (int s = 0; s < N_SITES; s++) begin
            if (site_full[w.flavour][s])
                full_sites = {full_sites, 6'(s)};
            else
                free_sites = {free_sites, 6'(s)};
        end
        if (roll < 2) begin
            w.op = OP_CLEAR;
        end else if (roll < 4) begin
            w.op = OP_NOP;
        end else if (free_sites.size() == 0) begin
            w.op = OP_CLEAR;
        end else begin
            w.to_site = free_sites[$urandom_range(free_sites.size() - 1)];
            if (roll < 40 || full_sites.size() == 0) begin
                w.op = OP_PLACE;
            end else begin
                w.op = OP_HOP;
                w.from_site = full_sites[$urandom_range(full_sites.size() - 1)];
            end
        end
        return w;
    endfunction

    task automatic send_word(input op_word_t w);
        while (!no_idle && $urandom_range(99) < 15) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, w};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_outcomes = {pending_outcomes, track_hop_sign(w)};
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("result %0d: %s got %0d, want %0d", result_count, field, got, want);
        error_count++;
    endtask

    task automatic test_directed();
        send_word(make_word(OP_NOP, 1'b1, 63, 63, 63));
        send_word(make_word(OP_PLACE, 1'b0, 0, 0, 63));
        send_word(make_word(OP_PLACE, 1'b0, 0, 63, 0));
        send_word(make_word(OP_PLACE, 1'b0, 0, 63, 12));
        send_word(make_word(OP_PLACE, 1'b1, 0, 0, 5));
        send_word(make_word(OP_PLACE, 1'b0, 0, 10, 7));
        // crosses one particle, sign goes negative
        send_word(make_word(OP_HOP, 1'b0, 0, 20, 0));
        send_word(make_word(OP_HOP, 1'b0, 20, 20, 0));
        send_word(make_word(OP_HOP, 1'b0, 5, 30, 0));
        send_word(make_word(OP_HOP, 1'b0, 20, 63, 0));
        send_word(make_word(OP_HOP, 1'b0, 63, 62, 0));
        send_word(make_word(OP_HOP, 1'b0, 62, 0, 0));
        // same particle index placed a second time
        send_word(make_word(OP_PLACE, 1'b0, 0, 40, 63));
        send_word(make_word(OP_HOP, 1'b0, 40, 15, 0));
        send_word(make_word(OP_PLACE, 1'b1, 0, 30, 9));
        send_word(make_word(OP_HOP, 1'b1, 0, 63, 0));
        send_word(make_word(OP_HOP, 1'b1, 63, 1, 0));
        send_word(make_word(OP_CLEAR, 1'b1, 63, 63, 63));
        send_word(make_word(OP_HOP, 1'b0, 0, 5, 0));
        send_word(make_word(OP_PLACE, 1'b1, 0, 63, 42));
        send_word(make_word(OP_HOP, 1'b1, 63, 0, 0));
        send_word(make_word(OP_NOP, 1'b0, 0, 0, 0));
    endtask

    task automatic test_wellformed(input int count);
        repeat (count) send_word(pick_wellformed());
    endtask

    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        test_wellformed(count);
        no_idle = 1'b0;
    endtask

    task automatic test_noise(input int count);
        repeat (count) send_word(op_word_t'($urandom));
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 15);
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            got_word = m_axis_tdata[8:0];
            if (pending_outcomes.size() == 0) begin
                report_mismatch("word with nothing pending", int'(got_word), 0);
            end else begin
                want_word = pending_outcomes.pop_front();
                if (got_word.sign_negative !== want_word.sign_negative)
                    report_mismatch("sign_negative", got_word.sign_negative,
                                    want_word.sign_negative);
                if (got_word.hop_odd !== want_word.hop_odd)
                    report_mismatch("hop_odd", got_word.hop_odd, want_word.hop_odd);
                if (got_word.moved_particle !== want_word.moved_particle)
                    report_mismatch("moved_particle", got_word.moved_particle,
                                    want_word.moved_particle);
                if (got_word.bad_move !== want_word.bad_move)
                    report_mismatch("bad_move", got_word.bad_move, want_word.bad_move);
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        site_full = '{default: 1'b0};
        sign_neg = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_wellformed(700);
        test_back_to_back(300);
        test_wellformed(300);
        test_noise(150);
        s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (N_SITES + 8) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/fhst_pkg.sv
hdl/fhst_cell.sv
hdl/fermion_hop_sign_tracker.sv
sim/testbench.sv
